>>> hdl/scfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfe_pkg
// Types and constants shared by the segment chunk feature extractor.
// ----------------------------------------------------------------------------
package scfe_pkg;

  localparam int SITE_W     = 16;
  localparam int HAP_W      = 8;
  localparam int WIDX_W     = 10;
  localparam int WADDR_W    = HAP_W + WIDX_W;
  localparam int SITES      = 1 << SITE_W;
  localparam int WORDS      = 1 << WADDR_W;
  localparam int NUM_W      = SITE_W + 1;
  localparam int CNT_W      = 5;
  localparam int CHUNK_W    = 4;
  localparam int MAX_CHUNKS = 16;
  localparam logic [CNT_W-1:0] CHUNK_RESET = 5'd10;

  typedef enum logic [1:0] {
    MODE_SITE   = 2'd0,
    MODE_ALLELE = 2'd1,
    MODE_MARK   = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK_WR,
    ST_DIV,
    ST_CH_START,
    ST_CH_SITE,
    ST_CH_RD,
    ST_CH_ACC,
    ST_CH_OUT
  } state_t;

  typedef struct packed {
    mode_t        mode;
    logic [15:0]  site_index;
    logic [15:0]  end_site;
    logic [27:0]  bp_position;
    logic [31:0]  cm_position;
    logic [7:0]   hap_index;
    logic [7:0]   second_hap;
    logic [9:0]   word_index;
    logic [63:0]  allele_word;
  } seg_in_t;

  typedef struct packed {
    logic [3:0]   chunk_number;
    logic [27:0]  bp_span;
    logic [31:0]  gen_len;
    logic [16:0]  mismatches;
    logic [17:0]  corrections;
    logic         last_chunk;
  } seg_out_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
    logic [CNT_W-1:0] remainder;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> hdl/segment_chunk_feature_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_chunk_feature_extractor
// Site, allele and correction tables with per-chunk segment features.
// ----------------------------------------------------------------------------
// After reset the block sweeps the correction memory to zero, one word per
// cycle, through all 262144 words, and takes no transaction until that is done.
// A site or allele load is written as it is taken, a correction mark is read
// and then written back with the bit set. A query runs the length division,
// then per chunk a start step, a span step and, for every 64-site word the
// chunk touches, a read and an accumulate step, then an output step that waits
// on out_ready; the word loop reads both haplotypes' allele and correction
// words in the same cycle. One query runs at a time.
module segment_chunk_feature_extractor (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  scfe_pkg::seg_in_t    in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output scfe_pkg::seg_out_t   out_data,
  input  wire                  cfg_wr_en,
  input  wire  [4:0]           cfg_wr_data
);
  import scfe_pkg::*;

  // Memories
  logic [27:0] bp_mem     [0:SITES-1];
  logic [31:0] cm_mem     [0:SITES-1];
  logic [63:0] allele_mem [0:WORDS-1];
  logic [63:0] corr_mem   [0:WORDS-1];

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic [WADDR_W-1:0]   clr_r;
  seg_in_t              in_r;
  logic [NUM_W-1:0]     qn_r, rn_ext;
  logic [CNT_W-1:0]     rn_r, racc_r;
  logic [NUM_W-1:0]     cs_r, ce_r, ce_calc, ce_m1;
  logic [CHUNK_W-1:0]   chunk_r;
  logic [WIDX_W-1:0]    w_r;
  logic [27:0]          phys_r;
  logic [31:0]          gen_r;
  logic [16:0]          mm_r;
  logic [17:0]          corr_r;
  logic                 out_valid_r;
  seg_out_t             out_r;

  logic [27:0]          bp_a_r, bp_b_r;
  logic [31:0]          cm_a_r, cm_b_r;
  logic [63:0]          al_a_r, al_b_r, co_a_r, co_b_r;

  logic                 accept, carry, last, out_free;
  logic [CNT_W-1:0]     rsum;
  logic [NUM_W-1:0]     seg_len;
  logic [SITE_W-1:0]    site_ra, site_rb;
  logic [WADDR_W-1:0]   word_ra, word_rb, corr_ra, corr_wa;
  logic [63:0]          corr_wd, mask;
  logic                 corr_we, site_we, allele_we;
  logic [5:0]           lo, hi;
  logic [6:0]           pc_mm, pc_c1, pc_c2;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  scfe_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign seg_len  = (in_data.end_site < in_data.site_index) ? '0 :
                    NUM_W'(in_data.end_site) - NUM_W'(in_data.site_index) + 1'b1;
  assign rsum     = racc_r + rn_r;
  assign carry    = rsum >= cnt_r;
  assign ce_calc  = cs_r + qn_r + NUM_W'(carry);
  assign ce_m1    = ce_r - 1'b1;
  assign rn_ext   = NUM_W'(rn_r);
  assign last     = (CNT_W'(chunk_r) + 1'b1) == cnt_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:    if (&clr_r) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (accept && in_data.mode == MODE_MARK) state_nxt = ST_MARK_WR;
        else if (accept && in_data.mode == MODE_QUERY) state_nxt = ST_DIV;
      end
      ST_MARK_WR:  state_nxt = ST_IDLE;
      ST_DIV:      if (div_rsp.done) state_nxt = ST_CH_START;
      ST_CH_START: state_nxt = ST_CH_SITE;
      ST_CH_SITE:  state_nxt = (cs_r == ce_r) ? ST_CH_OUT : ST_CH_RD;
      ST_CH_RD:    state_nxt = ST_CH_ACC;
      ST_CH_ACC:   state_nxt = (w_r == ce_m1[SITE_W-1:6]) ? ST_CH_OUT : ST_CH_RD;
      ST_CH_OUT:   if (out_free) state_nxt = last ? ST_IDLE : ST_CH_START;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready         = 1'b0;
    site_we          = 1'b0;
    allele_we        = 1'b0;
    corr_we          = 1'b0;
    corr_wa          = {in_r.hap_index, in_r.site_index[SITE_W-1:6]};
    corr_wd          = co_a_r | (64'd1 << in_r.site_index[5:0]);
    corr_ra          = {in_r.hap_index, w_r};
    site_ra          = cs_r[SITE_W-1:0];
    site_rb          = SITE_W'(ce_calc - 1'b1);
    div_req.start    = 1'b0;
    div_req.dividend = seg_len;
    div_req.divisor  = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        corr_we = 1'b1;
        corr_wa = clr_r;
        corr_wd = '0;
      end
      ST_IDLE: begin
        in_ready      = 1'b1;
        site_we       = accept && in_data.mode == MODE_SITE;
        allele_we     = accept && in_data.mode == MODE_ALLELE;
        div_req.start = accept && in_data.mode == MODE_QUERY;
        corr_ra       = {in_data.hap_index, in_data.site_index[SITE_W-1:6]};
      end
      ST_MARK_WR: corr_we = 1'b1;
      default: ;
    endcase
  end

  assign word_ra = {in_r.hap_index, w_r};
  assign word_rb = {in_r.second_hap, w_r};

  always_ff @(posedge clk) begin
    if (site_we) begin
      bp_mem[in_data.site_index] <= in_data.bp_position;
      cm_mem[in_data.site_index] <= in_data.cm_position;
    end
    bp_a_r <= bp_mem[site_ra];
    bp_b_r <= bp_mem[site_rb];
    cm_a_r <= cm_mem[site_ra];
    cm_b_r <= cm_mem[site_rb];
  end

  always_ff @(posedge clk) begin
    if (allele_we) begin
      allele_mem[{in_data.hap_index, in_data.word_index}] <= in_data.allele_word;
    end
    al_a_r <= allele_mem[word_ra];
    al_b_r <= allele_mem[word_rb];
  end

  always_ff @(posedge clk) begin
    if (corr_we) begin
      corr_mem[corr_wa] <= corr_wd;
    end
    co_a_r <= corr_mem[corr_ra];
    co_b_r <= corr_mem[word_rb];
  end

  // Bit window of the current word inside the chunk.
  always_comb begin
    lo    = (w_r == cs_r[SITE_W-1:6]) ? cs_r[5:0] : 6'd0;
    hi    = (w_r == ce_m1[SITE_W-1:6]) ? ce_m1[5:0] : 6'd63;
    mask  = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));
    pc_mm = 7'($countones((al_a_r ^ al_b_r) & mask));
    pc_c1 = 7'($countones(co_a_r & mask));
    pc_c2 = (in_r.second_hap != in_r.hap_index) ? 7'($countones(co_b_r & mask)) : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cnt_r       <= CHUNK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_wr_en) begin
        if (cfg_wr_data == '0) cnt_r <= CNT_W'(1);
        else if (cfg_wr_data > CNT_W'(MAX_CHUNKS)) cnt_r <= CNT_W'(MAX_CHUNKS);
        else cnt_r <= cfg_wr_data;
      end
      if (state_r == ST_CH_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) in_r <= in_data;
    case (state_r)
      ST_DIV: begin
        qn_r    <= div_rsp.quotient;
        rn_r    <= div_rsp.remainder;
        cs_r    <= NUM_W'(in_r.site_index);
        racc_r  <= '0;
        chunk_r <= '0;
      end
      ST_CH_START: begin
        ce_r   <= ce_calc;
        racc_r <= carry ? CNT_W'(rsum - cnt_r) : rsum;
      end
      ST_CH_SITE: begin
        w_r    <= cs_r[SITE_W-1:6];
        mm_r   <= '0;
        corr_r <= '0;
        phys_r <= (cs_r != ce_r && bp_b_r >= bp_a_r) ? bp_b_r - bp_a_r : '0;
        gen_r  <= (cs_r != ce_r && cm_b_r >= cm_a_r) ? cm_b_r - cm_a_r : '0;
      end
      ST_CH_ACC: begin
        mm_r   <= mm_r + 17'(pc_mm);
        corr_r <= corr_r + 18'(pc_c1) + 18'(pc_c2);
        w_r    <= w_r + 1'b1;
      end
      ST_CH_OUT: begin
        if (out_free) begin
          out_r.chunk_number <= chunk_r;
          out_r.bp_span      <= phys_r;
          out_r.gen_len      <= gen_r;
          out_r.mismatches   <= mm_r;
          out_r.corrections  <= corr_r;
          out_r.last_chunk   <= last;
          chunk_r            <= chunk_r + 1'b1;
          cs_r               <= ce_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_rsp.done) |-> (div_rsp.remainder < cnt_r))
    else $error("division remainder not below chunk count");

  a_chunk_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CH_SITE) |-> (ce_r >= cs_r && ce_r <= rn_ext + NUM_W'(SITES)))
    else $error("chunk end before chunk start");

  a_mm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CH_OUT) |-> (NUM_W'(mm_r) <= ce_r - cs_r))
    else $error("mismatch count exceeds chunk sites");

  a_corr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CH_OUT) |-> (corr_r <= {(ce_r - cs_r), 1'b0}))
    else $error("correction count exceeds twice the chunk sites");

endmodule
`default_nettype wire

>>> hdl/scfe_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scfe_div
// Restoring divider, one quotient bit per cycle, for segment length / chunks.
// ----------------------------------------------------------------------------
module scfe_div (
  input  wire                  clk,
  input  wire                  rst_n,
  input  scfe_pkg::div_req_t   req,
  output scfe_pkg::div_rsp_t   rsp
);
  import scfe_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     step_r, step_nxt;
  logic [NUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     den_r, den_nxt;
  logic [CNT_W:0]       trial;
  logic                 ge;

  always_comb begin
    trial    = {rem_r, quo_r[NUM_W-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[NUM_W-2:0], ge};
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, den_r}) : CNT_W'(trial);
      step_nxt = step_r + 1'b1;
      if (step_r == CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the segment chunk feature extractor. It loads site,
// allele and correction tables, runs segment queries under several chunk
// counts with random stalls on both sides, and compares every chunk result
// against a behavioral prediction of the chunk features.
// ----------------------------------------------------------------------------
module tb;
  import scfe_pkg::*;

  localparam int LOW_SITES   = 128;
  localparam int TOP_FIRST   = 65530;
  localparam int STALL_LIMIT = 1000000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  seg_in_t   in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  seg_out_t  out_data;
  logic      cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  segment_chunk_feature_extractor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #6 clk = ~clk;

  // Predictor state.
  logic [27:0] bp_tab [0:SITES-1];
  logic [31:0] cm_tab [0:SITES-1];
  logic [63:0] allele_mem [bit [17:0]];
  logic [63:0] mark_mem [bit [17:0]];
  int unsigned chunks_now = 10;

  seg_in_t  pending_items [$];
  seg_out_t chunk_results [$];
  logic [7:0] known_haps [6] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd128, 8'd255};

  logic in_fire_q = 1'b0;
  logic calm = 1'b0;
  int errors = 0;
  int queries_done = 0;
  int results_seen = 0;
  int stall_cycles = 0;

  function automatic logic [63:0] word_of(input bit is_mark, input logic [7:0] h,
                                          input int w);
    bit [17:0] key;
    key = {h, w[9:0]};
    if (is_mark) return mark_mem.exists(key) ? mark_mem[key] : 64'd0;
    return allele_mem.exists(key) ? allele_mem[key] : 64'd0;
  endfunction

  task automatic predict_chunks(input seg_in_t it);
    int unsigned s, e, n, cs, ce, mm, corr;
    logic [63:0] a1, a2, c1, c2;
    seg_out_t r;
    case (it.mode)
      MODE_SITE: begin
        bp_tab[it.site_index] = it.bp_position;
        cm_tab[it.site_index] = it.cm_position;
      end
      MODE_ALLELE: allele_mem[{it.hap_index, it.word_index}] = it.allele_word;
      MODE_MARK: mark_mem[{it.hap_index, it.site_index[15:6]}] =
        word_of(1'b1, it.hap_index, int'(it.site_index[15:6])) |
        (64'd1 << it.site_index[5:0]);
      MODE_QUERY: begin
        queries_done++;
        s = it.site_index;
        e = it.end_site;
        n = (e < s) ? 0 : e - s + 1;
        for (int unsigned c = 0; c < chunks_now; c++) begin
          r = '0;
          cs = s + (c * n) / chunks_now;
          ce = s + ((c + 1) * n) / chunks_now;
          if (n != 0 && cs < ce) begin
            r.bp_span = (bp_tab[ce-1] >= bp_tab[cs]) ? bp_tab[ce-1] - bp_tab[cs] : '0;
            r.gen_len = (cm_tab[ce-1] >= cm_tab[cs]) ? cm_tab[ce-1] - cm_tab[cs] : '0;
            mm = 0;
            corr = 0;
            for (int unsigned p = cs; p < ce; p++) begin
              a1 = word_of(1'b0, it.hap_index, int'(p >> 6));
              a2 = word_of(1'b0, it.second_hap, int'(p >> 6));
              c1 = word_of(1'b1, it.hap_index, int'(p >> 6));
              c2 = word_of(1'b1, it.second_hap, int'(p >> 6));
              mm += a1[p % 64] ^ a2[p % 64];
              corr += c1[p % 64];
              if (it.second_hap != it.hap_index) corr += c2[p % 64];
            end
            r.mismatches = 17'(mm);
            r.corrections = 18'(corr);
          end
          r.chunk_number = 4'(c);
          r.last_chunk = (c + 1 == chunks_now);
          chunk_results.insert(chunk_results.size(), r);
        end
      end
      default: ;
    endcase
  endtask

  function automatic seg_in_t noise_item(input mode_t m);
    seg_in_t it;
    it = seg_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.mode = m;
    return it;
  endfunction

  function automatic seg_in_t query_item(input int a, input int b,
                                         input logic [7:0] h1, input logic [7:0] h2);
    seg_in_t it;
    it = noise_item(MODE_QUERY);
    it.site_index = 16'(a);
    it.end_site = 16'(b);
    it.hap_index = h1;
    it.second_hap = h2;
    return it;
  endfunction

  // Queries only touch sites and allele words that were loaded up front.
  function automatic seg_in_t random_item();
    seg_in_t it;
    int roll, a, b, t;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      if ($urandom_range(0, 9) == 0) begin
        // Empty segment: the end lies before the start.
        a = $urandom_range(1, 65535);
        b = $urandom_range(0, a - 1);
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          a = $urandom_range(TOP_FIRST, 65535);
          b = $urandom_range(TOP_FIRST, 65535);
        end else begin
          a = $urandom_range(0, LOW_SITES - 1);
          b = $urandom_range(0, LOW_SITES - 1);
        end
        if (b < a && $urandom_range(0, 5) != 0) begin
          t = a; a = b; b = t;
        end
      end
      it = query_item(a, b, known_haps[$urandom_range(0, 5)],
                      known_haps[$urandom_range(0, 5)]);
      if ($urandom_range(0, 6) == 0) it.second_hap = it.hap_index;
    end else if (roll < 65) begin
      it = noise_item(MODE_MARK);
      if ($urandom_range(0, 1)) begin
        it.hap_index = known_haps[$urandom_range(0, 5)];
        it.site_index = 16'($urandom_range(0, LOW_SITES - 1));
      end
    end else if (roll < 80) begin
      it = noise_item(MODE_ALLELE);
      if ($urandom_range(0, 1)) begin
        it.hap_index = known_haps[$urandom_range(0, 5)];
        it.word_index = 10'($urandom_range(0, 1));
      end
    end else begin
      it = noise_item(MODE_SITE);
      it.bp_position = 28'($urandom_range(0, 4000));
      if ($urandom_range(0, 2) != 0) it.site_index = 16'($urandom_range(0, LOW_SITES - 1));
    end
    return it;
  endfunction

  // Driver: a new transaction is offered once the previous one was taken.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_fire_q) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= calm || $urandom_range(0, 99) >= 8;
    end
  end

  // Monitor, predictor hook and watchdog.
  always @(posedge clk) begin
    in_fire_q <= in_valid && in_ready;
    if (rst_n && in_valid && in_ready) predict_chunks(in_data);
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (chunk_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %p", $realtime, out_data);
      end else begin
        if (out_data !== chunk_results[0])
          begin
          errors++;
          $display("%0t: chunk result differs, expected %p, actual %p",
                   $realtime, chunk_results[0], out_data);
        end
        void'(chunk_results.pop_front());
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles without a transaction", stall_cycles);
      $display("segment_chunk_feature_extractor: mismatch");
      $finish;
    end
  end

  task automatic set_chunks(input logic [4:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    chunks_now = (value == 0) ? 1 : (value > MAX_CHUNKS) ? MAX_CHUNKS : value;
  endtask

  // Waits until every queued transaction is taken and every result is back.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || chunk_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    seg_in_t it;
    logic [4:0] settings [6] = '{5'd31, 5'd0, 5'd16, 5'd10, 5'd3, 5'd7};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    set_chunks(settings[0]);

    // Table setup, then directed queries.
    for (int i = 0; i < LOW_SITES; i++) begin
      it = noise_item(MODE_SITE);
      it.site_index = 16'(i);
      it.bp_position = 28'(i * 150 + $urandom_range(0, 149));
      it.cm_position = 32'(i * 2000 + $urandom_range(0, 1999));
      pending_items.insert(pending_items.size(), it);
    end
    for (int i = TOP_FIRST; i < 65536; i++) begin
      it = noise_item(MODE_SITE);
      it.site_index = 16'(i);
      if (i == 65535) begin
        it.bp_position = '1;
        it.cm_position = '1;
      end
      pending_items.insert(pending_items.size(), it);
    end
    foreach (known_haps[h]) begin
      for (int w = 0; w < 3; w++) begin
        it = noise_item(MODE_ALLELE);
        it.hap_index = known_haps[h];
        it.word_index = (w == 2) ? 10'd1023 : 10'(w);
        if (h == 0) it.allele_word = '0;
        if (h == 5) it.allele_word = '1;
        pending_items.insert(pending_items.size(), it);
      end
    end
    it = noise_item(MODE_MARK);
    it.hap_index = 8'd0;
    it.site_index = 16'd0;
    pending_items.insert(pending_items.size(), it);
    it.hap_index = 8'd255;
    it.site_index = 16'd65535;
    pending_items.insert(pending_items.size(), it);
    it.site_index = 16'd65533;
    pending_items.insert(pending_items.size(), it);
    pending_items.insert(pending_items.size(), query_item(0, LOW_SITES - 1, 8'd0, 8'd255));
    pending_items.insert(pending_items.size(), query_item(0, LOW_SITES - 1, 8'd1, 8'd1));
    pending_items.insert(pending_items.size(), query_item(65535, 0, 8'd2, 8'd3));
    pending_items.insert(pending_items.size(), query_item(10, 12, 8'd2, 8'd128));
    pending_items.insert(pending_items.size(), query_item(TOP_FIRST, 65535, 8'd255, 8'd0));
    pending_items.insert(pending_items.size(), query_item(65535, 65535, 8'd255, 8'd255));
    // A site placed earlier on the map than its predecessor gives a clipped span.
    it = noise_item(MODE_SITE);
    it.site_index = 16'd100;
    it.bp_position = '0;
    it.cm_position = '0;
    pending_items.insert(pending_items.size(), it);
    pending_items.insert(pending_items.size(), query_item(50, 100, 8'd3, 8'd0));
    drain();

    for (int p = 1; p < 6; p++) begin
      set_chunks(settings[p]);
      calm = (p == 2);
      for (int i = 0; i < 64; i++) pending_items.insert(pending_items.size(), random_item());
      drain();
    end
    calm = 1'b0;

    $display("ran %0d queries with %0d chunk results checked over six chunk counts",
             queries_done, results_seen);
    if (errors == 0) begin
      $display("segment_chunk_feature_extractor: match");
    end else begin
      $display("segment_chunk_feature_extractor: mismatch");
    end
    $finish;
  end

endmodule

>>> segment_chunk_feature_extractor.f
hdl/scfe_pkg.sv
hdl/scfe_div.sv
hdl/segment_chunk_feature_extractor.sv
bench/tb.sv
